@@ design/cstr_pkg.sv @@
`default_nettype none

package cstr_pkg;

   localparam int unsigned QW = 16;
   localparam int unsigned CW = 24;
   localparam int unsigned OW = 32;
   localparam int unsigned NSTG = 8;

   typedef enum logic [1:0] {
      REG_C_ELEVEN    = 2'd0,
      REG_C_TWELVE    = 2'd1,
      REG_C_FORTYFOUR = 2'd2
   } reg_index_type;

   typedef logic [2:0][QW-1:0] row_type;

   typedef struct packed {
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;
      logic       last;
   } meta_type;

endpackage

`default_nettype wire

@@ design/cubic_stiffness_tensor_rotation_unit.sv @@
`default_nettype none
// Rotates a cubic stiffness tensor by each 3x3 rotation matrix that arrives.
// The three elastic constants are written through the csr_ port, which the
// user must do only while the block is idle; the block does not enforce it.
// Index 0 is C11, 1 is C12 and 2 is C44, other indexes are ignored. Each
// item on the req_ channel is one Q2.14 matrix. It yields 27 rsp_ items, one
// per (i, j, k) with k fastest, each carrying the three values for l = 0, 1,
// 2, rounded and saturated to 32 bits; rsp_last marks the final one.
// An item enters an eight-stage pipeline through a row sequencer that issues
// one row per cycle while rsp_stall does not hold a valid item; the next
// item is taken in the cycle that the last row of the previous one is
// issued, so no new item is taken while the rows of one are still issuing.
// While rsp_stall holds a valid item, the whole pipeline and the sequencer
// freeze; nothing is lost or repeated. An idle sequencer still accepts an
// item during such a stall. Reset empties the pipeline and clears the
// constants to zero.
module cubic_stiffness_tensor_rotation_unit #(
   parameter int unsigned ROT_FRAC_BITS = 14
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [cstr_pkg::CW-1:0]   csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [15:0]        req_r00,
   input  wire logic signed [15:0]        req_r01,
   input  wire logic signed [15:0]        req_r02,
   input  wire logic signed [15:0]        req_r10,
   input  wire logic signed [15:0]        req_r11,
   input  wire logic signed [15:0]        req_r12,
   input  wire logic signed [15:0]        req_r20,
   input  wire logic signed [15:0]        req_r21,
   input  wire logic signed [15:0]        req_r22,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_idx_i,
   output logic [1:0]                     rsp_idx_j,
   output logic [1:0]                     rsp_idx_k,
   output logic signed [31:0]             rsp_val_l0,
   output logic signed [31:0]             rsp_val_l1,
   output logic signed [31:0]             rsp_val_l2,
   output logic                           rsp_last
);
   import cstr_pkg::*;

   localparam int unsigned SHIFT = 4 * ROT_FRAC_BITS;
   localparam int unsigned ACC_W = (SHIFT + 2 > 100) ? SHIFT + 2 : 100;
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

   logic signed [CW-1:0] c11_ff, c12_ff, c44_ff;
   logic                 busy_ff, busy_in;
   logic [1:0]           i_ff, j_ff, k_ff, i_in, j_in, k_in;
   row_type              row_ff [3];
   logic                 en, accept, issue, row_end;
   logic                 valid_ff [1:NSTG];
   meta_type             meta_ff [1:NSTG];

   logic signed [QW-1:0] qi [3];
   logic signed [QW-1:0] qj [3];
   logic signed [QW-1:0] qk [3];
   logic signed [QW-1:0] ql [3][3];

   logic signed [31:0] a_ff [3];
   logic signed [31:0] e_ff [3];
   logic signed [31:0] h_ff [3];
   logic signed [31:0] b_ff [3][3];
   logic signed [31:0] f_ff [3][3];
   logic signed [31:0] g_ff [3][3];

   logic signed [33:0] sa_ff, se_ff, sh_ff;
   logic signed [33:0] sb_ff [3];
   logic signed [33:0] sf_ff [3];
   logic signed [33:0] sg_ff [3];
   logic signed [63:0] d_ff [3][3];

   logic signed [67:0] p1_ff [3];
   logic signed [67:0] p2_ff [3];
   logic signed [67:0] p3_ff [3];
   logic signed [65:0] dd_ff [3];

   logic signed [69:0] x_ff [3][3];
   logic signed [59:0] mh_ff [3][3];
   logic signed [58:0] ml_ff [3][3];
   logic signed [94:0] t_ff [3][3];
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] rnd [3];
   logic signed [OW-1:0]    val_in [3];
   logic signed [OW-1:0]    val_ff [3];
   logic signed [CW-1:0]    cst [3];

   function automatic row_type pick(logic [1:0] sel, row_type r0, row_type r1,
                                    row_type r2);
      row_type r;
      case (sel)
         2'd0:    r = r0;
         2'd1:    r = r1;
         default: r = r2;
      endcase
      return r;
   endfunction

   assign en        = !(valid_ff[NSTG] && rsp_stall);
   assign row_end   = (i_ff == 2'd2) && (j_ff == 2'd2) && (k_ff == 2'd2);
   assign issue     = busy_ff && en;
   assign req_stall = busy_ff && !(en && row_end);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      row_type ri, rj, rk;
      ri = pick(i_ff, row_ff[0], row_ff[1], row_ff[2]);
      rj = pick(j_ff, row_ff[0], row_ff[1], row_ff[2]);
      rk = pick(k_ff, row_ff[0], row_ff[1], row_ff[2]);
      for (int m = 0; m < 3; m++) begin
         qi[m] = $signed(ri[m]);
         qj[m] = $signed(rj[m]);
         qk[m] = $signed(rk[m]);
         for (int l = 0; l < 3; l++) begin
            ql[l][m] = $signed(row_ff[l][m]);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      if (issue) begin
         if (row_end) begin
            busy_in = 1'b0;
         end else if (k_ff != 2'd2) begin
            k_in = k_ff + 2'd1;
         end else begin
            k_in = 2'd0;
            if (j_ff != 2'd2) begin
               j_in = j_ff + 2'd1;
            end else begin
               j_in = 2'd0;
               i_in = i_ff + 2'd1;
            end
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         i_in    = 2'd0;
         j_in    = 2'd0;
         k_in    = 2'd0;
      end
   end

   assign cst[0] = c11_ff;
   assign cst[1] = c12_ff;
   assign cst[2] = c44_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rnd[l] = acc_ff[l] >>> SHIFT;
         if (&rnd[l][ACC_W-1:OW-1] || ~|rnd[l][ACC_W-1:OW-1]) begin
            val_in[l] = rnd[l][OW-1:0];
         end else if (rnd[l][ACC_W-1]) begin
            val_in[l] = {1'b1, {(OW-1){1'b0}}};
         end else begin
            val_in[l] = {1'b0, {(OW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c11_ff  <= '0;
         c12_ff  <= '0;
         c44_ff  <= '0;
         busy_ff <= 1'b0;
         i_ff    <= 2'd0;
         j_ff    <= 2'd0;
         k_ff    <= 2'd0;
         for (int s = 1; s <= NSTG; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_C_ELEVEN:    c11_ff <= $signed(csr_wdata);
               REG_C_TWELVE:    c12_ff <= $signed(csr_wdata);
               REG_C_FORTYFOUR: c44_ff <= $signed(csr_wdata);
               default:         ;
            endcase
         end
         busy_ff <= busy_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         k_ff    <= k_in;
         if (en) begin
            valid_ff[1] <= busy_ff;
            for (int s = 2; s <= NSTG; s++) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff[0] <= {req_r02, req_r01, req_r00};
         row_ff[1] <= {req_r12, req_r11, req_r10};
         row_ff[2] <= {req_r22, req_r21, req_r20};
      end
      if (en) begin
         meta_ff[1] <= '{i: i_ff, j: j_ff, k: k_ff, last: row_end};
         for (int s = 2; s <= NSTG; s++) begin
            meta_ff[s] <= meta_ff[s-1];
         end
         for (int m = 0; m < 3; m++) begin
            a_ff[m] <= 32'(qi[m] * qj[m]);
            e_ff[m] <= 32'(qi[m] * qk[m]);
            h_ff[m] <= 32'(qj[m] * qk[m]);
            for (int l = 0; l < 3; l++) begin
               b_ff[l][m] <= 32'(qk[m] * ql[l][m]);
               f_ff[l][m] <= 32'(qj[m] * ql[l][m]);
               g_ff[l][m] <= 32'(qi[m] * ql[l][m]);
            end
         end
         sa_ff <= 34'(a_ff[0]) + 34'(a_ff[1]) + 34'(a_ff[2]);
         se_ff <= 34'(e_ff[0]) + 34'(e_ff[1]) + 34'(e_ff[2]);
         sh_ff <= 34'(h_ff[0]) + 34'(h_ff[1]) + 34'(h_ff[2]);
         for (int l = 0; l < 3; l++) begin
            sb_ff[l] <= 34'(b_ff[l][0]) + 34'(b_ff[l][1]) + 34'(b_ff[l][2]);
            sf_ff[l] <= 34'(f_ff[l][0]) + 34'(f_ff[l][1]) + 34'(f_ff[l][2]);
            sg_ff[l] <= 34'(g_ff[l][0]) + 34'(g_ff[l][1]) + 34'(g_ff[l][2]);
            for (int m = 0; m < 3; m++) begin
               d_ff[l][m] <= 64'(a_ff[m] * b_ff[l][m]);
            end
            p1_ff[l] <= 68'(sa_ff * sb_ff[l]);
            p2_ff[l] <= 68'(se_ff * sf_ff[l]);
            p3_ff[l] <= 68'(sg_ff[l] * sh_ff);
            dd_ff[l] <= 66'(d_ff[l][0]) + 66'(d_ff[l][1]) + 66'(d_ff[l][2]);
            x_ff[l][0] <= 70'(dd_ff[l]);
            x_ff[l][1] <= 70'(p1_ff[l]) - 70'(dd_ff[l]);
            x_ff[l][2] <= 70'(p2_ff[l]) + 70'(p3_ff[l]) - (70'(dd_ff[l]) <<< 1);
            for (int t = 0; t < 3; t++) begin
               mh_ff[l][t] <= 60'($signed(x_ff[l][t][69:34]) * cst[t]);
               ml_ff[l][t] <= 59'($signed({1'b0, x_ff[l][t][33:0]}) * cst[t]);
               t_ff[l][t]  <= (95'(mh_ff[l][t]) <<< 34) + 95'(ml_ff[l][t]);
            end
            acc_ff[l] <= ACC_W'(t_ff[l][0]) + ACC_W'(t_ff[l][1])
                       + ACC_W'(t_ff[l][2]) + HALF;
            val_ff[l] <= val_in[l];
         end
      end
   end

   assign rsp_valid  = valid_ff[NSTG];
   assign rsp_idx_i  = meta_ff[NSTG].i;
   assign rsp_idx_j  = meta_ff[NSTG].j;
   assign rsp_idx_k  = meta_ff[NSTG].k;
   assign rsp_last   = meta_ff[NSTG].last;
   assign rsp_val_l0 = val_ff[0];
   assign rsp_val_l1 = val_ff[1];
   assign rsp_val_l2 = val_ff[2];

endmodule

`default_nettype wire

@@ tb/sv/cubic_stiffness_tensor_rotation_unit_tb.sv @@
`default_nettype none

module cubic_stiffness_tensor_rotation_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cstr_pkg::*;

   localparam int unsigned FRAC = 14;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned IDLE_LIMIT = 6000;

   typedef logic signed [15:0] matrix_type [3][3];
   typedef logic signed [23:0] consts_type [3];

   typedef struct {
      logic [1:0]  i;
      logic [1:0]  j;
      logic [1:0]  k;
      logic [31:0] v [3];
      logic        last;
   } tensor_row_type;

   class rotation_scoreboard;
      tensor_row_type rows_due [$];
      consts_type     elastic;
      int             errors;

      function new();
         elastic = '{default: '0};
         errors = 0;
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h, expected %h", what, got, want);
         errors++;
      endfunction

      function logic signed [23:0] stiffness(int m, int n, int p, int q);
         if (m == n) begin
            if (p != q) return 0;
            return (m == p) ? elastic[REG_C_ELEVEN] : elastic[REG_C_TWELVE];
         end
         if ((p == m && q == n) || (p == n && q == m)) return elastic[REG_C_FORTYFOUR];
         return 0;
      endfunction

      function logic [31:0] rotated_entry(matrix_type r, int i, int j, int k, int l);
         logic signed [127:0] acc;
         logic signed [127:0] t;
         logic signed [23:0]  c;
         acc = 0;
         for (int m = 0; m < 3; m++)
            for (int n = 0; n < 3; n++)
               for (int p = 0; p < 3; p++)
                  for (int q = 0; q < 3; q++) begin
                     c = stiffness(m, n, p, q);
                     if (c != 0) begin
                        t = 128'(r[i][m]);
                        t = t * r[j][n];
                        t = t * r[k][p];
                        t = t * r[l][q];
                        t = t * c;
                        acc = acc + t;
                     end
                  end
         acc = (acc + (128'sd1 <<< (4 * FRAC - 1))) >>> (4 * FRAC);
         if (acc > 128'sd2147483647) return 32'h7FFF_FFFF;
         if (acc < -128'sd2147483648) return 32'h8000_0000;
         return acc[31:0];
      endfunction

      function void note_matrix(matrix_type r);
         tensor_row_type row;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 3; k++) begin
                  row.i = 2'(i);
                  row.j = 2'(j);
                  row.k = 2'(k);
                  for (int l = 0; l < 3; l++) row.v[l] = rotated_entry(r, i, j, k, l);
                  row.last = (i == 2 && j == 2 && k == 2);
                  rows_due.push_back(row);
               end
      endfunction

      function void check_row(tensor_row_type got);
         tensor_row_type want;
         if (rows_due.size() == 0) begin
            report("row with no matrix outstanding", '0, '0);
            return;
         end
         want = rows_due.pop_front();
         if (got.i !== want.i) report("idx_i", got.i, want.i);
         if (got.j !== want.j) report("idx_j", got.j, want.j);
         if (got.k !== want.k) report("idx_k", got.k, want.k);
         for (int l = 0; l < 3; l++)
            if (got.v[l] !== want.v[l]) report($sformatf("val_l%0d", l), got.v[l], want.v[l]);
         if (got.last !== want.last) report("last", got.last, want.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [CW-1:0] csr_wdata;
   logic req_valid;
   logic req_stall;
   logic signed [15:0] req_r00, req_r01, req_r02, req_r10, req_r11, req_r12;
   logic signed [15:0] req_r20, req_r21, req_r22;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_idx_i, rsp_idx_j, rsp_idx_k;
   logic signed [31:0] rsp_val_l0, rsp_val_l1, rsp_val_l2;
   logic rsp_last;

   rotation_scoreboard sb;
   logic hold_off_req;
   int unsigned idle_cycles = 0;

   cubic_stiffness_tensor_rotation_unit #(.ROT_FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_r00(req_r00), .req_r01(req_r01), .req_r02(req_r02),
      .req_r10(req_r10), .req_r11(req_r11), .req_r12(req_r12),
      .req_r20(req_r20), .req_r21(req_r21), .req_r22(req_r22),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_idx_i(rsp_idx_i), .rsp_idx_j(rsp_idx_j), .rsp_idx_k(rsp_idx_k),
      .rsp_val_l0(rsp_val_l0), .rsp_val_l1(rsp_val_l1), .rsp_val_l2(rsp_val_l2),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      tensor_row_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.i = rsp_idx_i;
         got.j = rsp_idx_j;
         got.k = rsp_idx_k;
         got.v[0] = rsp_val_l0;
         got.v[1] = rsp_val_l1;
         got.v[2] = rsp_val_l2;
         got.last = rsp_last;
         sb.check_row(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned stretch;
      int unsigned mode;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_req) begin
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
            hold_off_req = 1'b0;
         end
         stretch = $urandom_range(1, 40);
         mode = $urandom_range(0, 2);
         repeat (stretch) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic write_reg(logic [1:0] index, logic [CW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index <= REG_C_FORTYFOUR) sb.elastic[index] = value;
   endtask

   task automatic load_constants(logic [CW-1:0] c11, logic [CW-1:0] c12, logic [CW-1:0] c44);
      write_reg(REG_C_ELEVEN, c11);
      write_reg(REG_C_TWELVE, c12);
      write_reg(REG_C_FORTYFOUR, c44);
      write_reg(REG_SPARE, 24'(($urandom)));
   endtask

   task automatic send_matrix(matrix_type r);
      req_valid <= 1'b1;
      {req_r00, req_r01, req_r02} <= {r[0][0], r[0][1], r[0][2]};
      {req_r10, req_r11, req_r12} <= {r[1][0], r[1][1], r[1][2]};
      {req_r20, req_r21, req_r22} <= {r[2][0], r[2][1], r[2][2]};
      do @(posedge clock); while (req_stall);
      sb.note_matrix(r);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.rows_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic matrix_type fill_matrix(logic signed [15:0] value);
      matrix_type r;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++) r[a][b] = value;
      return r;
   endfunction

   function automatic matrix_type signed_permutation();
      matrix_type r;
      int perm [3];
      int s;
      perm = '{0, 1, 2};
      for (int a = 2; a > 0; a--) begin
         int b;
         b = $urandom_range(0, a);
         s = perm[a];
         perm[a] = perm[b];
         perm[b] = s;
      end
      r = fill_matrix(16'sd0);
      for (int a = 0; a < 3; a++)
         r[a][perm[a]] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      return r;
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type r;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) return signed_permutation();
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            if (kind < 6) r[a][b] = 16'(int'($urandom_range(0, 32768)) - 16384);
            else r[a][b] = 16'($urandom);
      return r;
   endfunction

   task automatic random_burst_run(int unsigned count, bit gaps);
      int unsigned burst;
      burst = 0;
      repeat (count) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 6);
            if (gaps && $urandom_range(0, 1)) pause_sender($urandom_range(1, 60));
         end
         send_matrix(random_matrix());
         burst--;
      end
   endtask

   initial begin
      matrix_type r;
      sb = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      {req_r00, req_r01, req_r02, req_r10, req_r11, req_r12, req_r20, req_r21, req_r22} = '0;
      hold_off_req = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_matrix(signed_permutation());
      wait_drained();

      load_constants(24'd168400, 24'd121400, 24'd75400);
      r = fill_matrix(16'sd0);
      r[0][0] = 16384; r[1][1] = 16384; r[2][2] = 16384;
      send_matrix(r);
      send_matrix(fill_matrix(16'sd0));
      r = fill_matrix(16'sd0);
      r[0][0] = 11585; r[0][1] = -11585; r[1][0] = 11585; r[1][1] = 11585; r[2][2] = 16384;
      send_matrix(r);
      r = fill_matrix(16'sd0);
      r[0][1] = 16384; r[1][2] = 16384; r[2][0] = 16384;
      send_matrix(r);
      r = fill_matrix(16'sd0);
      r[0][0] = 1; r[1][1] = -1; r[2][2] = 1;
      send_matrix(r);
      r = fill_matrix(16'sd0);
      r[0][0] = 12345; r[0][2] = -3000; r[1][1] = 20000; r[2][0] = 7; r[2][2] = -32768;
      send_matrix(r);
      for (int s = 0; s < 4; s++) send_matrix(signed_permutation());
      wait_drained();

      load_constants(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send_matrix(fill_matrix(16'sh7FFF));
      send_matrix(fill_matrix(16'sh8000));
      send_matrix(fill_matrix(16'sh0001));
      send_matrix(fill_matrix(16'shFFFF));
      random_burst_run(16, 1'b1);
      wait_drained();

      load_constants(24'h800000, 24'h7FFFFF, 24'h800000);
      send_matrix(fill_matrix(16'sh8000));
      send_matrix(fill_matrix(16'sh7FFF));
      hold_off_req = 1'b1;
      random_burst_run(8, 1'b0);
      random_burst_run(12, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         load_constants(24'($urandom), 24'($urandom), 24'($urandom));
         random_burst_run(14, 1'b1);
         wait_drained();
      end

      load_constants(24'd0, 24'd0, 24'd0);
      random_burst_run(4, 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.rows_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
design/cstr_pkg.sv
design/cubic_stiffness_tensor_rotation_unit.sv
tb/sv/cubic_stiffness_tensor_rotation_unit_tb.sv
